/* rtl/core/gfja_pkg.sv */
`default_nettype none
package gfja_pkg;

	localparam int unsigned NUM_CFG = 7;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VEL_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EPS2  = 3'd6;

	// multiply step kinds
	localparam logic [3:0] K_DR2   = 4'd0;
	localparam logic [3:0] K_R2INV = 4'd1;
	localparam logic [3:0] K_MR2   = 4'd2;
	localparam logic [3:0] K_U     = 4'd3;
	localparam logic [3:0] K_ACC   = 4'd4;
	localparam logic [3:0] K_SD    = 4'd5;
	localparam logic [3:0] K_T     = 4'd6;
	localparam logic [3:0] K_Q     = 4'd7;
	localparam logic [3:0] K_JERK  = 4'd8;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// product right shift
	localparam logic [1:0] SH24 = 2'd0;
	localparam logic [1:0] SH32 = 2'd1;
	localparam logic [1:0] SH40 = 2'd2;
	localparam logic [1:0] SH48 = 2'd3;

	typedef struct packed {
		logic       load;
		logic       norm_init;
		logic       norm_step;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       rinv_load;
		logic       mul_start;
		logic [3:0] kind;
		logic [1:0] axis;
		logic       emit;
	} gfja_cmd_t;

	typedef struct packed {
		logic r2_zero;
		logic norm_more;
		logic sqrt_done;
		logic div_done;
		logic mul_done;
		logic out_free;
	} gfja_sts_t;

endpackage
`default_nettype wire

/* rtl/core/gravity_force_jerk_accumulator.sv */
`default_nettype none
// Pairwise softened gravity: acceleration and jerk on one target particle.
// Target position/velocity and squared softening are written through the
// cfg_we/cfg_index/cfg_data port; the user must do so only while the block
// is idle, as the block does not enforce it. Source particles arrive on the
// input channel (in_valid/in_stall); a beat is taken when in_valid is high
// and in_stall low. Each source is worked one at a time: one shared 32x32
// multiplier runs 23 multiplies, each an issue, a busy run and a handoff,
// plus a 2-bit-per-cycle normalize, a 32-step square root and a 33-step
// reciprocal divide. A self source skips all of the arithmetic, and a zero
// distance without softening stops after the squared-distance multiplies.
// A beat with last_source set puts the six sums on the output channel
// (out_valid/out_stall) and clears them in an emit state, and the sums
// show up the cycle after it. The result sits in an output register: new
// sources are taken while it waits, and a stalled result holds until
// taken. The next last beat waits for that slot.
// Reset clears the sums, the configuration registers and both channels.
module gravity_force_jerk_accumulator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] source_pos_x,
	input  wire logic signed [31:0] source_pos_y,
	input  wire logic signed [31:0] source_pos_z,
	input  wire logic signed [31:0] source_vel_x,
	input  wire logic signed [31:0] source_vel_y,
	input  wire logic signed [31:0] source_vel_z,
	input  wire logic [31:0]        source_mass,
	input  wire logic               is_self,
	input  wire logic               last_source,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [63:0]      accel_x,
	output logic signed [63:0]      accel_y,
	output logic signed [63:0]      accel_z,
	output logic signed [63:0]      jerk_x,
	output logic signed [63:0]      jerk_y,
	output logic signed [63:0]      jerk_z
);
	import gfja_pkg::*;

	gfja_cmd_t cmd;
	gfja_sts_t sts;

	gfja_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.is_self     (is_self),
		.last_source (last_source),
		.sts         (sts),
		.cmd         (cmd)
	);

	gfja_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.source_pos_x (source_pos_x),
		.source_pos_y (source_pos_y),
		.source_pos_z (source_pos_z),
		.source_vel_x (source_vel_x),
		.source_vel_y (source_vel_y),
		.source_vel_z (source_vel_z),
		.source_mass  (source_mass),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.jerk_x       (jerk_x),
		.jerk_y       (jerk_y),
		.jerk_z       (jerk_z),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
`default_nettype wire

/* rtl/core/gfja_mul.sv */
`default_nettype none
module gfja_mul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	input  wire logic [1:0]         sh,
	output logic                    done,
	output logic signed [63:0]      res
);
	import gfja_pkg::*;

	logic         busy_q;
	logic [2:0]   cnt_q;
	logic         done_q;
	logic [63:0]  ma_q, mb_q;
	logic         neg_q;
	logic [1:0]   sh_q;
	logic [63:0]  pp_q;
	logic [1:0]   pps_q;
	logic [127:0] acc_q;
	logic signed [63:0] res_q;

	logic [31:0]  ah, bh;
	logic [63:0]  pp_d;
	logic [1:0]   pps_d;
	logic [127:0] ppx;
	logic [127:0] shifted;
	logic [63:0]  mag;
	logic signed [63:0] fin;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin ah = ma_q[31:0];  bh = mb_q[31:0];  pps_d = 2'd0; end
			2'd1: begin ah = ma_q[31:0];  bh = mb_q[63:32]; pps_d = 2'd1; end
			2'd2: begin ah = ma_q[63:32]; bh = mb_q[31:0];  pps_d = 2'd1; end
			default: begin ah = ma_q[63:32]; bh = mb_q[63:32]; pps_d = 2'd2; end
		endcase
		pp_d = ah * bh;
	end

	always_comb begin
		unique case (pps_q)
			2'd0: ppx = {64'b0, pp_q};
			2'd1: ppx = {32'b0, pp_q, 32'b0};
			default: ppx = {pp_q, 64'b0};
		endcase
	end

	always_comb begin
		unique case (sh_q)
			SH24: shifted = acc_q >> 24;
			SH32: shifted = acc_q >> 32;
			SH40: shifted = acc_q >> 40;
			default: shifted = acc_q >> 48;
		endcase
		mag = ((|shifted[127:64]) || shifted[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : shifted[63:0];
		fin = neg_q ? -$signed(mag) : $signed(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a[63] ? 64'(-a) : 64'(a);
			mb_q  <= b[63] ? 64'(-b) : 64'(b);
			neg_q <= a[63] ^ b[63];
			sh_q  <= sh;
			acc_q <= '0;
		end else if (busy_q) begin
			if (cnt_q < 3'd4) begin
				pp_q  <= pp_d;
				pps_q <= pps_d;
			end
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4)
				acc_q <= acc_q + ppx;
			if (cnt_q == 3'd5)
				res_q <= fin;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("multiply started while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q) else $error("multiply did not go busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q))) else $error("done without a run");

endmodule
`default_nettype wire

/* rtl/core/gfja_dp.sv */
`default_nettype none
module gfja_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [31:0]           cfg_data,
	input  wire logic signed [31:0]    source_pos_x,
	input  wire logic signed [31:0]    source_pos_y,
	input  wire logic signed [31:0]    source_pos_z,
	input  wire logic signed [31:0]    source_vel_x,
	input  wire logic signed [31:0]    source_vel_y,
	input  wire logic signed [31:0]    source_vel_z,
	input  wire logic [31:0]           source_mass,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [63:0]         accel_x,
	output logic signed [63:0]         accel_y,
	output logic signed [63:0]         accel_z,
	output logic signed [63:0]         jerk_x,
	output logic signed [63:0]         jerk_y,
	output logic signed [63:0]         jerk_z,
	input  wire gfja_pkg::gfja_cmd_t   cmd,
	output gfja_pkg::gfja_sts_t        sts
);
	import gfja_pkg::*;

	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] SMIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
		input logic signed [63:0] y);
		logic signed [63:0] s;
		s = x + y;
		if (x[63] == y[63] && s[63] != x[63])
			return x[63] ? SMIN : SMAX;
		return s;
	endfunction

	logic signed [31:0] tpos_q [3];
	logic signed [31:0] tvel_q [3];
	logic [31:0]        eps2_q;

	logic signed [32:0] dr_q [3];
	logic signed [32:0] dv_q [3];
	logic [31:0]        mass_q;
	logic [41:0]        r2_q;

	logic [61:0] n_q;
	logic [5:0]  e_q;
	logic [61:0] sn_q;
	logic [62:0] root_q, bit_q;
	logic [62:0] rem_q, d_q;
	logic [32:0] quot_q, mask_q;

	logic signed [63:0] ri_q, r2inv_q, mr2_q, sd_q, p_q, q_q;
	logic signed [63:0] u_q [3];
	logic signed [63:0] asum_q [3];
	logic signed [63:0] jsum_q [3];
	logic signed [63:0] aout_q [3];
	logic signed [63:0] jout_q [3];
	logic               out_valid_q;

	logic signed [31:0] spos [3];
	logic signed [31:0] svel [3];
	logic [62:0]        trial;
	logic               sq_ge;

	logic signed [63:0] mul_a, mul_b, mul_res;
	logic [1:0]         mul_sh;
	logic               mul_done;
	logic signed [63:0] dr_ext, dv_ext;

	assign spos[0] = source_pos_x;
	assign spos[1] = source_pos_y;
	assign spos[2] = source_pos_z;
	assign svel[0] = source_vel_x;
	assign svel[1] = source_vel_y;
	assign svel[2] = source_vel_z;

	assign dr_ext = 64'(dr_q[cmd.axis]);
	assign dv_ext = 64'(dv_q[cmd.axis]);

	always_comb begin
		unique case (cmd.kind)
			K_DR2:   begin mul_a = dr_ext;           mul_b = dr_ext;           mul_sh = SH24; end
			K_R2INV: begin mul_a = ri_q;             mul_b = ri_q;             mul_sh = SH48; end
			K_MR2:   begin mul_a = r2inv_q;          mul_b = 64'(mass_q);      mul_sh = SH32; end
			K_U:     begin mul_a = dr_ext;           mul_b = ri_q;             mul_sh = SH24; end
			K_ACC:   begin mul_a = u_q[cmd.axis];    mul_b = mr2_q;            mul_sh = SH40; end
			K_SD:    begin mul_a = u_q[cmd.axis];    mul_b = dv_ext;           mul_sh = SH40; end
			K_T:     begin mul_a = sd_q;             mul_b = u_q[cmd.axis];    mul_sh = SH40; end
			K_Q:     begin mul_a = p_q;              mul_b = ri_q;             mul_sh = SH40; end
			K_JERK:  begin mul_a = q_q;              mul_b = mr2_q;            mul_sh = SH24; end
			default: begin mul_a = '0;               mul_b = '0;               mul_sh = SH24; end
		endcase
	end

	gfja_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.res    (mul_res)
	);

	assign trial = root_q + bit_q;
	assign sq_ge = {1'b0, sn_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				tpos_q[k] <= '0;
				tvel_q[k] <= '0;
				asum_q[k] <= '0;
				jsum_q[k] <= '0;
			end
			eps2_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POS_X: tpos_q[0] <= cfg_data;
					CFG_POS_Y: tpos_q[1] <= cfg_data;
					CFG_POS_Z: tpos_q[2] <= cfg_data;
					CFG_VEL_X: tvel_q[0] <= cfg_data;
					CFG_VEL_Y: tvel_q[1] <= cfg_data;
					CFG_VEL_Z: tvel_q[2] <= cfg_data;
					CFG_EPS2:  eps2_q    <= cfg_data;
					default: ;
				endcase
			end
			if (mul_done && cmd.kind == K_ACC)
				asum_q[cmd.axis] <= sat_add(asum_q[cmd.axis], mul_res);
			if (mul_done && cmd.kind == K_JERK)
				jsum_q[cmd.axis] <= sat_add(jsum_q[cmd.axis], mul_res);
			if (cmd.emit) begin
				for (int k = 0; k < 3; k++) begin
					asum_q[k] <= '0;
					jsum_q[k] <= '0;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 3; k++) begin
				dr_q[k] <= 33'(spos[k]) - 33'(tpos_q[k]);
				dv_q[k] <= 33'(svel[k]) - 33'(tvel_q[k]);
			end
			mass_q <= source_mass;
			r2_q   <= 42'(eps2_q);
			sd_q   <= '0;
		end
		if (mul_done) begin
			unique case (cmd.kind)
				K_DR2:   r2_q <= r2_q + mul_res[41:0];
				K_R2INV: r2inv_q <= mul_res;
				K_MR2:   mr2_q <= mul_res;
				K_U:     u_q[cmd.axis] <= mul_res;
				K_SD:    sd_q <= sd_q + mul_res;
				K_T:     p_q <= dv_ext - (mul_res + (mul_res <<< 1));
				K_Q:     q_q <= mul_res;
				default: ;
			endcase
		end
		if (cmd.norm_init) begin
			n_q <= 62'(r2_q);
			e_q <= '0;
		end else if (cmd.norm_step && sts.norm_more) begin
			n_q <= n_q << 2;
			e_q <= e_q + 6'd2;
		end
		if (cmd.sqrt_init) begin
			sn_q   <= n_q;
			root_q <= '0;
			bit_q  <= 63'h1 << 62;
		end else if (cmd.sqrt_step) begin
			if (sq_ge) begin
				sn_q   <= sn_q - trial[61:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_init) begin
			rem_q  <= 63'h1 << 62;
			d_q    <= {root_q[30:0], 32'b0};
			quot_q <= '0;
			mask_q <= 33'h1 << 32;
		end else if (cmd.div_step) begin
			if (rem_q >= d_q) begin
				rem_q  <= rem_q - d_q;
				quot_q <= quot_q | mask_q;
			end
			d_q    <= d_q >> 1;
			mask_q <= mask_q >> 1;
		end
		if (cmd.rinv_load)
			ri_q <= $signed(64'(quot_q) << (e_q[5:1] - 5'd10));
		if (cmd.emit) begin
			for (int k = 0; k < 3; k++) begin
				aout_q[k] <= asum_q[k];
				jout_q[k] <= jsum_q[k];
			end
		end
	end

	assign sts.r2_zero   = (r2_q == '0);
	assign sts.norm_more = (e_q <= 6'd58) && (n_q[61:60] == 2'b00);
	assign sts.sqrt_done = (bit_q == '0);
	assign sts.div_done  = (mask_q == '0);
	assign sts.mul_done  = mul_done;
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign accel_x   = aout_q[0];
	assign accel_y   = aout_q[1];
	assign accel_z   = aout_q[2];
	assign jerk_x    = jout_q[0];
	assign jerk_y    = jout_q[1];
	assign jerk_z    = jout_q[2];

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall)) else $error("result beat overwritten");
	a_rinv_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rinv_load |-> (e_q >= 6'd20)) else $error("rinv shift out of range");
	a_emit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_valid_q && asum_q[0] == '0 && jsum_q[2] == '0))
		else $error("sums not cleared on emit");

endmodule
`default_nettype wire

/* rtl/core/gfja_ctrl.sv */
`default_nettype none
module gfja_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                is_self,
	input  wire logic                last_source,
	input  wire gfja_pkg::gfja_sts_t sts,
	output gfja_pkg::gfja_cmd_t      cmd
);
	import gfja_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ISSUE = 4'd1;
	localparam logic [3:0] S_WAIT  = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_NORM  = 4'd4;
	localparam logic [3:0] S_SQRT  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_RINV  = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [3:0] kind_q, kind_d;
	logic [1:0] axis_q, axis_d;
	logic       last_q;

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		axis_d  = axis_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					kind_d  = K_DR2;
					axis_d  = AXIS_X;
					state_d = is_self ? S_FIN : S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.mul_start = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (sts.mul_done) begin
					state_d = S_ISSUE;
					unique case (kind_q)
						K_DR2: begin
							if (axis_q == AXIS_Z) state_d = S_CHK;
							else axis_d = axis_q + 2'd1;
						end
						K_R2INV: kind_d = K_MR2;
						K_MR2: begin kind_d = K_U; axis_d = AXIS_X; end
						K_U: begin
							if (axis_q == AXIS_Z) begin kind_d = K_ACC; axis_d = AXIS_X; end
							else axis_d = axis_q + 2'd1;
						end
						K_ACC: begin
							if (axis_q == AXIS_Z) begin kind_d = K_SD; axis_d = AXIS_X; end
							else axis_d = axis_q + 2'd1;
						end
						K_SD: begin
							if (axis_q == AXIS_Z) begin kind_d = K_T; axis_d = AXIS_X; end
							else axis_d = axis_q + 2'd1;
						end
						K_T: kind_d = K_Q;
						K_Q: kind_d = K_JERK;
						K_JERK: begin
							if (axis_q == AXIS_Z) state_d = S_FIN;
							else begin kind_d = K_T; axis_d = axis_q + 2'd1; end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_CHK: begin
				if (sts.r2_zero) begin
					state_d = S_FIN;
				end else begin
					cmd.norm_init = 1'b1;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				cmd.norm_step = 1'b1;
				if (!sts.norm_more) begin
					cmd.sqrt_init = 1'b1;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				if (sts.sqrt_done) begin
					cmd.div_init = 1'b1;
					state_d = S_DIV;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_RINV;
				else cmd.div_step = 1'b1;
			end
			S_RINV: begin
				cmd.rinv_load = 1'b1;
				kind_d  = K_R2INV;
				state_d = S_ISSUE;
			end
			S_FIN: begin
				state_d = last_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.kind = kind_q;
		cmd.axis = axis_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_DR2;
			axis_q  <= AXIS_X;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			axis_q  <= axis_d;
			if (state_q == S_IDLE && in_valid)
				last_q <= last_source;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> (state_q == S_WAIT)) else $error("stray multiply done");
	a_self_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && is_self) |=> (state_q == S_FIN))
		else $error("self source not skipped");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && sts.out_free) |=> (state_q == S_IDLE))
		else $error("emit did not return to idle");

endmodule
`default_nettype wire
